/* rtl/ray_unit_box_slab_intersect_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the box slab intersection block.
// ---------------------------------------------------------------------------
`ifndef RAY_UNIT_BOX_SLAB_INTERSECT_MACROS_SVH
`define RAY_UNIT_BOX_SLAB_INTERSECT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define RBS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Property checked on every clock edge, reset included.
`define RBS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/rbs_pkg.sv */
// ---------------------------------------------------------------------------
// Box slab intersection package
// Shared widths, constants and lane types.
// ---------------------------------------------------------------------------
`default_nettype none
package rbs_pkg;
    localparam int WORD_W = 32;
    localparam int DEF_FRAC_BITS = 16;
    localparam int NUM_W = 64;
    localparam int AXES = 3;
    localparam logic signed [WORD_W-1:0] FX_MAX = 32'sh7FFFFFFF;
    localparam logic signed [WORD_W-1:0] FX_MIN = 32'sh80000000;

    typedef struct packed {
        logic                     ok;
        logic signed [WORD_W-1:0] lo;
        logic signed [WORD_W-1:0] hi;
    } slab_t;
endpackage
`default_nettype wire

/* rtl/rbs_ray_if.sv */
// ---------------------------------------------------------------------------
// Ray channel interface
// Valid and ready handshake carrying one ray word.
// ---------------------------------------------------------------------------
`default_nettype none
interface rbs_ray_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    input ready);
    modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  output ready);
endinterface
`default_nettype wire

/* rtl/rbs_hit_if.sv */
// ---------------------------------------------------------------------------
// Hit channel interface
// Valid and ready handshake carrying one hit word.
// ---------------------------------------------------------------------------
`default_nettype none
interface rbs_hit_if;
    logic               valid;
    logic               ready;
    logic               hit;
    logic signed [31:0] t_near;
    logic signed [31:0] t_far;
    modport source (output valid, hit, t_near, t_far, input ready);
    modport sink (input valid, hit, t_near, t_far, output ready);
endinterface
`default_nettype wire

/* rtl/rbs_div.sv */
// ---------------------------------------------------------------------------
// Pipelined unsigned divider of magnitudes
// Restoring division, one quotient bit per stage, truncation toward zero.
// ---------------------------------------------------------------------------
`default_nettype none
module rbs_div #(
    parameter int QW = 48,
    parameter int DW = 32
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic [QW-1:0] num_mag,
    input  wire logic [DW-1:0] den_mag,
    output logic      [QW-1:0] quo
);
    localparam int RW = DW + 1;

    logic [QW-1:0] q_reg [QW+1];
    logic [RW-1:0] r_reg [QW+1];
    logic [DW-1:0] d_reg [QW+1];

    always_comb
    begin
        q_reg[0] = num_mag;
        r_reg[0] = '0;
        d_reg[0] = den_mag;
    end

    for (genvar s = 0; s < QW; s++) begin : g_stage
        logic [RW-1:0] shifted;
        logic [RW:0]   diff;
        assign shifted = {r_reg[s][RW-2:0], q_reg[s][QW-1]};
        assign diff = {1'b0, shifted} - {2'b00, d_reg[s]};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d_reg[s+1] <= d_reg[s];
                if (!diff[RW])
                begin
                    r_reg[s+1] <= diff[RW-1:0];
                    q_reg[s+1] <= {q_reg[s][QW-2:0], 1'b1};
                end
                else
                begin
                    r_reg[s+1] <= shifted;
                    q_reg[s+1] <= {q_reg[s][QW-2:0], 1'b0};
                end
            end
        end
    end

    assign quo = q_reg[QW];

    logic unused_rst;
    assign unused_rst = rst_n;
endmodule
`default_nettype wire

/* rtl/rbs_lane.sv */
// ---------------------------------------------------------------------------
// Slab lane
// Computes the near and far plane distances of one axis.
// ---------------------------------------------------------------------------
`default_nettype none
module rbs_lane #(
    parameter int FRAC_BITS = rbs_pkg::DEF_FRAC_BITS,
    parameter int LAT = 32 + FRAC_BITS + 2
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         en,
    input  wire logic [31:0]  org,
    input  wire logic [31:0]  dir,
    output rbs_pkg::slab_t    slab
);
    import rbs_pkg::*;

    localparam int QW = 33 + FRAC_BITS;
    localparam int DL = QW;

    logic signed [32:0] org_s, na, nb;
    logic [32:0]        na_mag, nb_mag;
    logic [31:0]        d_mag;
    logic               d_neg, d_zero, org_in_box;
    logic [QW-1:0]      qa_in, qb_in, qa, qb;
    logic [QW-1:0]      one_ext;

    assign one_ext = QW'(1) << FRAC_BITS;
    assign org_s = {org[31], org};
    assign na = -(33'sd1 <<< FRAC_BITS) - org_s;
    assign nb = (33'sd1 <<< FRAC_BITS) - org_s;
    assign na_mag = na[32] ? 33'(-na) : na;
    assign nb_mag = nb[32] ? 33'(-nb) : nb;
    assign d_neg = dir[31];
    assign d_mag = d_neg ? 32'(-dir) : dir;
    assign d_zero = (dir == '0);
    assign org_in_box = ($signed(org_s) >= -$signed({1'b0, one_ext[32:0]})) &&
                        ($signed(org_s) <= $signed({1'b0, one_ext[32:0]}));
    assign qa_in = QW'(na_mag) << FRAC_BITS;
    assign qb_in = QW'(nb_mag) << FRAC_BITS;

    rbs_div #(.QW(QW), .DW(32)) u_div_a (
        .clk(clk), .rst_n(rst_n), .en(en), .num_mag(qa_in),
        .den_mag(d_zero ? 32'd1 : d_mag), .quo(qa));
    rbs_div #(.QW(QW), .DW(32)) u_div_b (
        .clk(clk), .rst_n(rst_n), .en(en), .num_mag(qb_in),
        .den_mag(d_zero ? 32'd1 : d_mag), .quo(qb));

    logic [3:0] side_reg [DL+1];
    assign side_reg[0] = {na[32] ^ d_neg, nb[32] ^ d_neg, d_zero, org_in_box};
    for (genvar s = 0; s < DL; s++) begin : g_side
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[s+1] <= side_reg[s];
            end
        end
    end

    function automatic logic signed [31:0] sat(input logic [QW-1:0] m, input logic neg);
        logic signed [QW:0] v;
        begin
            v = neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
            if (v > $signed((QW+1)'(FX_MAX)))
                sat = FX_MAX;
            else if (v < $signed({{(QW+1-32){1'b1}}, FX_MIN}))
                sat = FX_MIN;
            else
                sat = v[31:0];
        end
    endfunction

    logic signed [31:0] a_reg, b_reg, a_next, b_next;
    logic [3:0]         fl_reg;
    assign a_next = sat(qa, side_reg[DL][3]);
    assign b_next = sat(qb, side_reg[DL][2]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
            fl_reg <= side_reg[DL];
        end
    end

    always_comb
    begin
        if (fl_reg[1])
        begin
            slab.ok = fl_reg[0];
            slab.lo = FX_MIN;
            slab.hi = FX_MAX;
        end
        else
        begin
            slab.ok = 1'b1;
            slab.lo = (a_reg > b_reg) ? b_reg : a_reg;
            slab.hi = (a_reg > b_reg) ? a_reg : b_reg;
        end
    end

    logic unused_lat;
    assign unused_lat = (LAT == DL + 1);
endmodule
`default_nettype wire

/* rtl/ray_unit_box_slab_intersect.sv */
// ---------------------------------------------------------------------------
// Ray against unit box, slab method
// Three axis lanes of pipelined dividers feed a merging stage.
// ---------------------------------------------------------------------------
// Channel | Dir | Word
// ray     | in  | origin_x/y/z, dir_x/y/z, signed fixed point
// res     | out | hit, t_near, t_far
//
// One ray enters per cycle while the result is not stalled; each lane's
// bit-per-stage divider pipeline is followed by a saturation and a merge
// stage. The whole pipeline advances only when the output register is free
// or being taken, so a stall on the result freezes every stage.
// Reset clears the valid bits of the pipeline.
`default_nettype none
module ray_unit_box_slab_intersect #(
    parameter int FRAC_BITS = rbs_pkg::DEF_FRAC_BITS
) (
    input wire logic clk,
    input wire logic rst_n,
    rbs_ray_if.sink  ray,
    rbs_hit_if.source res
);
    import rbs_pkg::*;
    `include "ray_unit_box_slab_intersect_macros.svh"

    localparam int LAT = 33 + FRAC_BITS + 1;

    logic           en;
    logic [LAT-1:0] v_reg, v_next;
    slab_t          slab [AXES];
    logic           o_valid_reg;
    logic           o_hit_reg;
    logic signed [31:0] o_near_reg, o_far_reg;

    assign en = !o_valid_reg || res.ready;
    assign ray.ready = en;
    assign v_next = {v_reg[LAT-2:0], ray.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
            o_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= v_next;
            o_valid_reg <= v_reg[LAT-1];
        end
    end

    rbs_lane #(.FRAC_BITS(FRAC_BITS), .LAT(LAT)) u_lx (
        .clk(clk), .rst_n(rst_n), .en(en), .org(ray.origin_x), .dir(ray.dir_x),
        .slab(slab[0]));
    rbs_lane #(.FRAC_BITS(FRAC_BITS), .LAT(LAT)) u_ly (
        .clk(clk), .rst_n(rst_n), .en(en), .org(ray.origin_y), .dir(ray.dir_y),
        .slab(slab[1]));
    rbs_lane #(.FRAC_BITS(FRAC_BITS), .LAT(LAT)) u_lz (
        .clk(clk), .rst_n(rst_n), .en(en), .org(ray.origin_z), .dir(ray.dir_z),
        .slab(slab[2]));

    logic signed [31:0] m_near, m_far;
    logic               m_ok, m_hit;

    always_comb
    begin
        m_near = FX_MIN;
        m_far = FX_MAX;
        m_ok = 1'b1;
        for (int i = 0; i < AXES; i++)
        begin
            if (!slab[i].ok)
                m_ok = 1'b0;
            else
            begin
                if (slab[i].lo > m_near)
                    m_near = slab[i].lo;
                if (slab[i].hi < m_far)
                    m_far = slab[i].hi;
            end
        end
        m_hit = m_ok && (m_near <= m_far);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_hit_reg <= m_hit;
            o_near_reg <= m_hit ? m_near : '0;
            o_far_reg <= m_hit ? m_far : '0;
        end
    end

    assign res.valid = o_valid_reg;
    assign res.hit = o_hit_reg;
    assign res.t_near = o_near_reg;
    assign res.t_far = o_far_reg;

    `RBS_ASSERT(a_stall_hold, (res.valid && !res.ready) |=> (res.valid && $stable(res.t_near)), "result changed under stall")
    `RBS_ASSERT(a_miss_zero, (res.valid && !res.hit) |-> (res.t_near == '0 && res.t_far == '0), "miss with nonzero distances")
    `RBS_ASSERT(a_hit_order, (res.valid && res.hit) |-> (res.t_near <= res.t_far), "hit with near above far")
    `RBS_ASSERT_ALWAYS(a_ready_free, (!o_valid_reg) |-> ray.ready, "input blocked with empty output")
endmodule
`default_nettype wire

/* sim/ray_unit_box_slab_intersect_checker.sv */
// ---------------------------------------------------------------------------
// Box slab intersection checker
// Watches the ray and hit channels, predicts each hit word from the ray
// word that caused it and compares the two field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module ray_unit_box_slab_intersect_checker #(
    parameter int FRAC_BITS = rbs_pkg::DEF_FRAC_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    rbs_ray_if          ray,
    rbs_hit_if          res,
    output int          fail_count,
    output int          pending_hits
);
    import rbs_pkg::*;

    typedef struct packed {
        logic                     hit;
        logic signed [WORD_W-1:0] t_near;
        logic signed [WORD_W-1:0] t_far;
    } hit_word_t;

    hit_word_t hit_queue[$];

    function automatic logic signed [63:0] sat_word(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic hit_word_t box_hit(input logic signed [31:0] org[3],
                                          input logic signed [31:0] dir[3]);
        logic signed [63:0] one;
        logic signed [63:0] t_lo;
        logic signed [63:0] t_hi;
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic signed [63:0] o;
        logic signed [63:0] d;
        logic               ok;
        hit_word_t          w;
        one = 64'sd1 <<< FRAC_BITS;
        t_lo = -64'sd2147483648;
        t_hi = 64'sd2147483647;
        ok = 1'b1;
        for (int ax = 0; ax < 3; ax++) begin
            o = org[ax];
            d = dir[ax];
            if (d == 0) begin
                if (o < -one || o > one)
                    ok = 1'b0;
            end else begin
                a = sat_word(((-one - o) <<< FRAC_BITS) / d);
                b = sat_word(((one - o) <<< FRAC_BITS) / d);
                if (a > b) begin
                    o = a;
                    a = b;
                    b = o;
                end
                if (a > t_lo)
                    t_lo = a;
                if (b < t_hi)
                    t_hi = b;
            end
        end
        if (ok && t_lo <= t_hi) begin
            w.hit = 1'b1;
            w.t_near = t_lo[31:0];
            w.t_far = t_hi[31:0];
        end else begin
            w = '0;
        end
        return w;
    endfunction

    initial fail_count = 0;

    always @(posedge clk) begin
        logic signed [31:0] org[3];
        logic signed [31:0] dir[3];
        hit_word_t          want;
        if (rst_n) begin
            if (ray.valid && ray.ready) begin
                org[0] = ray.origin_x;
                org[1] = ray.origin_y;
                org[2] = ray.origin_z;
                dir[0] = ray.dir_x;
                dir[1] = ray.dir_y;
                dir[2] = ray.dir_z;
                hit_queue.push_back(box_hit(org, dir));
            end
            if (res.valid && res.ready) begin
                if (hit_queue.size() == 0) begin
                    $display("%0t: unexpected hit word hit=%0d near=%0d far=%0d",
                             $time, res.hit, res.t_near, res.t_far);
                    fail_count <= fail_count + 1;
                end else begin
                    want = hit_queue.pop_front();
                    if (want.hit !== res.hit || want.t_near !== res.t_near
                        || want.t_far !== res.t_far) begin
                        $display("%0t: expected hit=%0d near=%0d far=%0d, got hit=%0d near=%0d far=%0d",
                                 $time, want.hit, want.t_near, want.t_far,
                                 res.hit, res.t_near, res.t_far);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
        pending_hits <= hit_queue.size();
    end
endmodule

/* sim/tb.sv */
// ---------------------------------------------------------------------------
// Box slab intersection testbench
// Drives directed and random rays with random idling and a long result
// stall, and gives the verdict from the checker's failure count and a watchdog.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;
    localparam int LATENCY = 35 + rbs_pkg::DEF_FRAC_BITS;
    localparam int WATCHDOG_LIMIT = 20000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_hits;
    int   idle_count;
    bit   calm;
    bit   hold_res;

    rbs_ray_if ray ();
    rbs_hit_if res ();

    ray_unit_box_slab_intersect dut (.clk(clk), .rst_n(rst_n), .ray(ray), .res(res));

    ray_unit_box_slab_intersect_checker u_checker (
        .clk(clk), .rst_n(rst_n), .ray(ray), .res(res),
        .fail_count(fail_count), .pending_hits(pending_hits)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic signed [31:0] pick_val();
        case ($urandom_range(0, 7))
            0: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
            1: return 32'sd0;
            2: return $urandom_range(0, 1) ? 32'sh00010000 : -32'sh00010000;
            3: return $urandom();
            4: return $signed($urandom_range(0, 3)) - 32'sd1;
            default: return $signed($urandom_range(0, 32'h00060000)) - 32'sh00030000;
        endcase
    endfunction

    task automatic send_ray(input logic signed [31:0] ox, input logic signed [31:0] oy,
                            input logic signed [31:0] oz, input logic signed [31:0] dx,
                            input logic signed [31:0] dy, input logic signed [31:0] dz);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            ray.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        ray.valid <= 1'b1;
        ray.origin_x <= ox;
        ray.origin_y <= oy;
        ray.origin_z <= oz;
        ray.dir_x <= dx;
        ray.dir_y <= dy;
        ray.dir_z <= dz;
        @(posedge clk);
        while (!ray.ready)
            @(posedge clk);
    endtask

    initial
    begin
        res.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_res)
                res.ready <= 1'b0;
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                res.ready <= 1'b0;
                repeat ($urandom_range(1, 7) - 1) @(posedge clk);
            end
            else
                res.ready <= 1'b1;
        end
    end

    initial
    begin
        idle_count = 0;
        forever
        begin
            @(posedge clk);
            if ((ray.valid && ray.ready) || (res.valid && res.ready))
                idle_count = 0;
            else
                idle_count++;
            if (idle_count >= WATCHDOG_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin
        ray.valid = 1'b0;
        ray.origin_x = '0;
        ray.origin_y = '0;
        ray.origin_z = '0;
        ray.dir_x = '0;
        ray.dir_y = '0;
        ray.dir_z = '0;
        calm = 1'b0;
        hold_res = 1'b0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_ray(0, 0, 0, 32'sh00010000, 32'sh00010000, 32'sh00010000);
        send_ray(0, 0, 0, 0, 0, 0);
        send_ray(32'sh00020000, 0, 0, 0, 0, 0);
        send_ray(32'sh00010000, -32'sh00010000, 32'sh00010000, 0, 0, 0);
        send_ray(32'sh00010001, 0, 0, 0, 32'sh00010000, 0);
        send_ray(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000,
                 32'sh80000000);
        send_ray(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                 32'sh7FFFFFFF);
        send_ray(32'sh80000000, 0, 0, 1, 0, 0);
        send_ray(32'sh7FFFFFFF, 0, 0, -1, 0, 0);
        send_ray(-32'sh00050000, 0, 0, 32'sh00010000, 0, 0);
        send_ray(-32'sh00050000, 32'sh00050000, 0, 32'sh00010000, 0, 0);
        send_ray(0, 0, 0, 1, 1, -1);
        send_ray(32'sh00008000, 32'sh00008000, 32'sh00008000, -32'sh00010000, 32'sh00020000,
                 32'sh00030000);
        send_ray(32'shFFFFFFFF, 32'shFFFFFFFF, 32'shFFFFFFFF, 32'shFFFFFFFF, 32'shFFFFFFFF,
                 32'shFFFFFFFF);

        for (int i = 0; i < 800; i++)
        begin
            if (i == 200)
            begin
                ray.valid <= 1'b0;
                @(posedge clk);
                while (pending_hits != 0)
                    @(posedge clk);
            end
            if (i == 300)
            begin
                hold_res = 1'b1;
                fork
                    begin
                        repeat (3 * LATENCY) @(posedge clk);
                        hold_res = 1'b0;
                    end
                join_none
            end
            if (i == 650)
                calm = 1'b1;
            send_ray(pick_val(), pick_val(), pick_val(), pick_val(), pick_val(), pick_val());
        end

        ray.valid <= 1'b0;
        @(posedge clk);
        while (pending_hits != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

/* filelist.f */
+incdir+rtl
rtl/rbs_pkg.sv
rtl/rbs_ray_if.sv
rtl/rbs_hit_if.sv
rtl/rbs_div.sv
rtl/rbs_lane.sv
rtl/ray_unit_box_slab_intersect.sv
sim/ray_unit_box_slab_intersect_checker.sv
sim/tb.sv
